>>> rtl/b64f_pkg.sv
// Package with shared types, constants and the character decode table for the base64 sample decoder.
`timescale 1ns / 1ps

package b64f_pkg;

  // Field widths fixed by the block's interface.
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 18;
  localparam int unsigned CFG_W    = 18;
  localparam int unsigned STATUS_W = 3;

  // Word counter saturates at its all-ones value.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Reset value of the sample limit register.
  localparam logic [CFG_W-1:0] MAX_SAMPLES_RESET = CFG_W'(48000);

  // Character codes of interest.
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3d;

  // Sextet offsets of the alphabet ranges.
  localparam logic [CHAR_W-1:0] SX_LOWER_BASE = 8'd26;
  localparam logic [CHAR_W-1:0] SX_DIGIT_BASE = 8'd52;
  localparam logic [5:0]        SX_PLUS       = 6'd62;
  localparam logic [5:0]        SX_SLASH      = 6'd63;

  // Block status codes, in the order reported on the result channel.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_LENGTH    = 3'd1,
    ST_NOWORD    = 3'd2,
    ST_TOOMANY   = 3'd3,
    ST_BADCHAR   = 3'd4,
    ST_NONFINITE = 3'd5
  } status_t;

  // Decoded character: legal flag and sextet value (zero when illegal).
  typedef struct packed {
    logic       legal;
    logic [5:0] value;
  } sextet_t;

  // Map one character code onto its base64 sextet.
  function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] c);
    sextet_t     s;
    logic [CHAR_W-1:0] t;
    s = '0;
    t = '0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      t = c - CH_UPPER_A;
      s = '{legal: 1'b1, value: t[5:0]};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      t = c - CH_LOWER_A + SX_LOWER_BASE;
      s = '{legal: 1'b1, value: t[5:0]};
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      t = c - CH_DIGIT_0 + SX_DIGIT_BASE;
      s = '{legal: 1'b1, value: t[5:0]};
    end else if (c == CH_PLUS) begin
      s = '{legal: 1'b1, value: SX_PLUS};
    end else if (c == CH_SLASH) begin
      s = '{legal: 1'b1, value: SX_SLASH};
    end
    return s;
  endfunction

endpackage

>>> rtl/b64f_if.sv
// Valid/ready channel interfaces for the character input and the sample result.
`timescale 1ns / 1ps

interface b64f_in_if
  import b64f_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface b64f_out_if
  import b64f_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                word_valid;
  logic [WORD_W-1:0]   sample_bits;
  logic [COUNT_W-1:0]  word_index;
  logic                block_done;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output word_valid, output sample_bits, output word_index,
                  output block_done, output status, input ready);
  modport sink   (input valid, input word_valid, input sample_bits, input word_index,
                  input block_done, input status, output ready);
endinterface

>>> rtl/base64_f32le_sample_decoder.sv
// Top level of the strict base64 decoder that assembles little-endian float samples.
//
// Usage:
//   chars   - sink channel, one base64 character per transaction; last marks the
//             final character of a block.
//   samples - source channel; a transaction is produced for every completed
//             32-bit word and for every last character (both may coincide).
//             On the last character block_done is set and status holds the
//             block verdict; if it is not OK, all words of that block are void.
//   cfg_wr_en / cfg_wr_data - writes the sample limit; write only while idle.
// A result appears on samples in the cycle after its character is taken.
// Throughput: one character per cycle when not stalled; the decode table, byte
//   packing and the status compare sit between the input and the result register.
// The result register lets a new character be taken while a result waits; when
//   the receiver stalls with a result held, chars.ready drops until it is taken.
// Reset clears the decode state and the result valid flag and sets the sample
//   limit to 48000; the limit in force is also capped at MAX_SAMPLES_BOUND.
`timescale 1ns / 1ps

module base64_f32le_sample_decoder
  import b64f_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES_BOUND = 262143
) (
  input  logic             clk,
  input  logic             rst,
  b64f_in_if.sink          chars,
  b64f_out_if.source       samples,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  // Width wide enough for both the register and the bound.
  localparam int unsigned BOUND_W = $clog2(MAX_SAMPLES_BOUND + 1);
  localparam int unsigned LIM_W   = (BOUND_W > CFG_W) ? BOUND_W : CFG_W;
  localparam logic [LIM_W-1:0] BOUND = LIM_W'(MAX_SAMPLES_BOUND);

  // Decode state.
  logic [1:0]         qpos, qpos_next;
  logic [5:0]         prev, prev_next;
  logic [1:0]         pad_seen, pad_seen_next;
  logic               closed, closed_next;
  logic [23:0]        bacc, bacc_next;
  logic [1:0]         bcnt, bcnt_next;
  logic [COUNT_W-1:0] wcount, wcount_next;
  status_t            sticky, sticky_next;
  logic [CFG_W-1:0]   max_samples;

  // Result register.
  logic                out_valid;
  logic                res_word_valid;
  logic [WORD_W-1:0]   res_bits;
  logic [COUNT_W-1:0]  res_index;
  logic                res_done;
  status_t             res_status;

  // Combinational results for the current character.
  sextet_t            sx_dec;
  logic [5:0]         sx;
  logic               pad;
  logic               bad;
  logic               have;
  logic [7:0]         data_byte;
  logic [1:0]         pad_upd;
  logic               word_done;
  logic [WORD_W-1:0]  word;
  logic [LIM_W-1:0]   limit;
  status_t            block_status;
  logic               produce;
  logic               accept;

  assign accept      = chars.valid && chars.ready;
  assign chars.ready = !out_valid || samples.ready;

  // Limit in force is the register capped at the bound.
  assign limit = (LIM_W'(max_samples) > BOUND) ? BOUND : LIM_W'(max_samples);

  // Character check, byte extraction and word assembly.
  always_comb begin
    sx_dec        = sextet_of(chars.char_code);
    sx            = sx_dec.legal ? sx_dec.value : 6'd0;
    pad           = (chars.char_code == CH_PAD);
    bad           = closed;
    have          = 1'b0;
    data_byte     = '0;
    pad_upd       = pad_seen;

    case (qpos)
      2'd0: begin
        if (!sx_dec.legal) bad = 1'b1;
      end
      2'd1: begin
        if (!sx_dec.legal) bad = 1'b1;
        data_byte = {prev, sx[5:4]};
        have      = 1'b1;
      end
      2'd2: begin
        if (pad) begin
          pad_upd = 2'd1;
          if (prev[3:0] != 4'd0) bad = 1'b1;
        end else begin
          if (!sx_dec.legal) bad = 1'b1;
          data_byte = {prev[3:0], sx[5:2]};
          have      = 1'b1;
        end
      end
      default: begin
        if (pad_seen != 2'd0) begin
          if (pad) pad_upd = 2'd2;
          else     bad = 1'b1;
        end else if (pad) begin
          pad_upd = 2'd1;
          if (prev[1:0] != 2'd0) bad = 1'b1;
        end else begin
          if (!sx_dec.legal) bad = 1'b1;
          data_byte = {prev[1:0], sx};
          have      = 1'b1;
        end
      end
    endcase

    // Bad character outranks OK and non-finite only.
    sticky_next = sticky;
    if (bad && (sticky == ST_OK || sticky == ST_NONFINITE)) sticky_next = ST_BADCHAR;

    // Quartet bookkeeping.
    if (qpos == 2'd3) begin
      prev_next     = '0;
      closed_next   = closed || (pad_upd != 2'd0);
      pad_seen_next = '0;
    end else begin
      prev_next     = sx;
      closed_next   = closed;
      pad_seen_next = pad_upd;
    end
    qpos_next = qpos + 2'd1;

    // Byte packing into the word, first byte lowest.
    word        = {data_byte, bacc};
    word_done   = have && (bcnt == 2'd3);
    bacc_next   = bacc;
    bcnt_next   = bcnt;
    wcount_next = wcount;
    if (word_done) begin
      bacc_next = '0;
      bcnt_next = '0;
      if (wcount == COUNT_MAX) sticky_next = ST_TOOMANY;
      else                     wcount_next = wcount + COUNT_W'(1);
      if (word[30:23] == 8'hff && sticky_next == ST_OK) sticky_next = ST_NONFINITE;
    end else if (have) begin
      case (bcnt)
        2'd0:    bacc_next[7:0]   = data_byte;
        2'd1:    bacc_next[15:8]  = data_byte;
        default: bacc_next[23:16] = data_byte;
      endcase
      bcnt_next = bcnt + 2'd1;
    end

    // Block verdict on the last character.
    if (qpos_next != 2'd0) begin
      block_status = ST_LENGTH;
    end else if (bcnt_next != 2'd0 || wcount_next == '0) begin
      block_status = ST_NOWORD;
    end else if (sticky_next == ST_TOOMANY || LIM_W'(wcount_next) > limit) begin
      block_status = ST_TOOMANY;
    end else begin
      block_status = sticky_next;
    end

    produce = word_done || chars.last;
  end

  // Decode state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      qpos        <= '0;
      prev        <= '0;
      pad_seen    <= '0;
      closed      <= 1'b0;
      bacc        <= '0;
      bcnt        <= '0;
      wcount      <= '0;
      sticky      <= ST_OK;
      max_samples <= MAX_SAMPLES_RESET;
    end else begin
      if (cfg_wr_en) max_samples <= cfg_wr_data;
      if (accept) begin
        if (chars.last) begin
          qpos     <= '0;
          prev     <= '0;
          pad_seen <= '0;
          closed   <= 1'b0;
          bacc     <= '0;
          bcnt     <= '0;
          wcount   <= '0;
          sticky   <= ST_OK;
        end else begin
          qpos     <= qpos_next;
          prev     <= prev_next;
          pad_seen <= pad_seen_next;
          closed   <= closed_next;
          bacc     <= bacc_next;
          bcnt     <= bcnt_next;
          wcount   <= wcount_next;
          sticky   <= sticky_next;
        end
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= produce;
    end else if (samples.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept && produce) begin
      res_word_valid <= word_done;
      res_bits       <= word_done ? word : '0;
      res_index      <= word_done ? wcount : '0;
      res_done       <= chars.last;
      res_status     <= chars.last ? block_status : ST_OK;
    end
  end

  assign samples.valid        = out_valid;
  assign samples.word_valid   = res_word_valid;
  assign samples.sample_bits  = res_bits;
  assign samples.word_index   = res_index;
  assign samples.block_done   = res_done;
  assign samples.status       = res_status;

endmodule

>>> rtl/b64f_checker.sv
// Port-level checker for the base64 sample decoder and its bind to the top level.
`timescale 1ns / 1ps

module b64f_checker
  import b64f_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic                word_valid,
  input logic [WORD_W-1:0]   sample_bits,
  input logic [COUNT_W-1:0]  word_index,
  input logic                block_done,
  input logic [STATUS_W-1:0] status
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Every result carries a word, a block verdict, or both.
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_valid || block_done))
    else $error("empty result transaction");

  // A last character always yields a block verdict in the next cycle.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> (out_valid && block_done))
    else $error("last character gave no block verdict");

  // Fields without their flag read as zero, and the status code stays in range.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((word_valid || (sample_bits == '0 && word_index == '0)) &&
                   (block_done || status == ST_OK) && status <= ST_NONFINITE))
    else $error("result field inconsistent with its flag");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_bits) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind base64_f32le_sample_decoder b64f_checker u_b64f_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (chars.valid),
  .in_ready     (chars.ready),
  .in_last      (chars.last),
  .out_valid    (samples.valid),
  .out_ready    (samples.ready),
  .word_valid   (samples.word_valid),
  .sample_bits  (samples.sample_bits),
  .word_index   (samples.word_index),
  .block_done   (samples.block_done),
  .status       (samples.status)
);
